/* design/led_strip_wave_pattern_generator_unit_defines.svh */
// Assertion macros used by the checker file.
// Both expect i_clk and i_rst_n in scope.
`ifndef LED_STRIP_WAVE_PATTERN_GENERATOR_UNIT_DEFINES_SVH
`define LED_STRIP_WAVE_PATTERN_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define LSWP_CHK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LSWP_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lswp_pkg.sv */
`default_nettype none

package lswp_pkg;

    // Strip size default
    localparam int NUM_LEDS_DEF = 29;

    // Fixed-point constants (Q1.16 / Q2.16)
    localparam int              Q16_TWO  = 131072;
    localparam logic [16:0]     ONE_Q16  = 17'h10000;
    localparam logic [17:0]     TWO_Q16  = 18'h20000;

    // Configuration register indexes
    localparam logic [2:0] CFG_PERIOD   = 3'd0;
    localparam logic [2:0] CFG_GAIN     = 3'd1;
    localparam logic [2:0] CFG_MODE     = 3'd2;
    localparam logic [2:0] CFG_BEND_X   = 3'd3;
    localparam logic [2:0] CFG_BEND_Y   = 3'd4;
    localparam logic [2:0] CFG_SPATIAL  = 3'd5;

    // Waveform modes
    localparam logic [2:0] WAVE_BEND    = 3'd0;
    localparam logic [2:0] WAVE_POW_MAX = 3'd5;

    // Phase divider: two quotient bits per cycle over 50 dividend bits
    localparam logic [4:0] PH_LAST_STEP = 5'd24;

    typedef struct packed {
        logic [15:0] period_ms;
        logic [7:0]  peak_gain;
        logic [2:0]  wave_mode;
        logic [15:0] bend_x;
        logic [15:0] bend_y;
        logic [3:0]  spatial_cycles;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        period_ms:      16'd5000,
        peak_gain:      8'd254,
        wave_mode:      3'd5,
        bend_x:         16'd32768,
        bend_y:         16'd32768,
        spatial_cycles: 4'd4
    };

    // One LED on its way from the sequencer into the shaping pipeline
    typedef struct packed {
        logic        valid;
        logic [5:0]  led;
        logic        last;
        logic [16:0] x;
    } t_seq_item;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BUSY,
        PH_DONE
    } t_ph_state;

endpackage

`default_nettype wire

/* design/led_strip_wave_pattern_generator_unit.sv */
// Channel   Handshake                  Payload
// ------    -------------------------  -----------------------------------------
// in        i_in_valid / o_in_ready    i_time_ms
// out       o_out_valid / i_out_ready  o_led_index, o_level, o_last_led
// cfg       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A frame passes through the phase divider (two quotient bits per cycle),
// then yields NUM_LEDS items, one per cycle while the output is not held.
// The phase divider works on the next frame while the LED sequencer emits.
// Synchronous active-low reset clears control state and restores the registers.
// A held output item stalls the whole shaping pipeline; nothing is dropped.
`default_nettype none

module led_strip_wave_pattern_generator_unit #(
    parameter int NUM_LEDS = lswp_pkg::NUM_LEDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_time_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [5:0]       o_led_index,
    output logic [7:0]       o_level,
    output logic             o_last_led,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import lswp_pkg::*;

    t_cfg        r_cfg;
    logic        t_valid;
    logic        t_ready;
    logic [16:0] t_phase;
    logic        en;
    t_seq_item   seq_item;

    // Register file; unknown indexes are ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERIOD:  r_cfg.period_ms      <= i_cfg_data;
                CFG_GAIN:    r_cfg.peak_gain      <= i_cfg_data[7:0];
                CFG_MODE:    r_cfg.wave_mode      <= i_cfg_data[2:0];
                CFG_BEND_X:  r_cfg.bend_x         <= i_cfg_data;
                CFG_BEND_Y:  r_cfg.bend_y         <= i_cfg_data;
                CFG_SPATIAL: r_cfg.spatial_cycles <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    lswp_phase u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_period   (r_cfg.period_ms),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_time_ms  (i_time_ms),
        .o_t_valid  (t_valid),
        .o_t        (t_phase),
        .i_t_ready  (t_ready)
    );

    lswp_seq #(
        .NUM_LEDS (NUM_LEDS)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_spatial_cycles (r_cfg.spatial_cycles),
        .i_en             (en),
        .i_t_valid        (t_valid),
        .i_t              (t_phase),
        .o_t_ready        (t_ready),
        .o_item           (seq_item)
    );

    lswp_shape u_shape (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (seq_item),
        .i_out_ready (i_out_ready),
        .o_en        (en),
        .o_out_valid (o_out_valid),
        .o_led_index (o_led_index),
        .o_level     (o_level),
        .o_last_led  (o_last_led)
    );

endmodule

`default_nettype wire

/* design/lswp_phase.sv */
`default_nettype none

module lswp_phase (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_period,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_time_ms,
    output logic             o_t_valid,
    output logic [16:0]      o_t,
    input  wire logic        i_t_ready
);
    import lswp_pkg::*;

    t_ph_state   r_state;
    t_ph_state   n_state;
    logic [4:0]  r_cnt;
    logic [32:0] r_num;
    logic [15:0] r_rem;
    logic [16:0] r_q;
    logic [15:0] per;
    logic [16:0] step_a;
    logic [16:0] step_b;
    logic        accept;

    // One restoring step: {quotient bit, new remainder}
    function automatic logic [16:0] div_step(input logic [15:0] rem,
                                             input logic       bit_in,
                                             input logic [15:0] dv);
        logic [16:0] r;
        r = {rem, bit_in};
        if (r >= {1'b0, dv}) begin
            div_step = {1'b1, 16'(r - {1'b0, dv})};
        end else begin
            div_step = {1'b0, r[15:0]};
        end
    endfunction

    // A zero period counts as one
    assign per = (i_period == '0) ? 16'd1 : i_period;

    // Two steps per cycle
    assign step_a = div_step(r_rem, r_num[32], per);
    assign step_b = div_step(step_a[15:0], r_num[31], per);

    assign accept = i_in_valid & o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            PH_IDLE: begin
                if (i_in_valid) n_state = PH_BUSY;
            end
            PH_BUSY: begin
                if (r_cnt == PH_LAST_STEP) n_state = PH_DONE;
            end
            PH_DONE: begin
                if (i_t_ready) n_state = i_in_valid ? PH_BUSY : PH_IDLE;
            end
            default: n_state = PH_IDLE;
        endcase
    end

    // Outputs: a new item is taken while the finished phase is handed off
    always_comb begin
        o_in_ready = 1'b0;
        o_t_valid  = 1'b0;
        unique case (r_state)
            PH_IDLE: o_in_ready = 1'b1;
            PH_BUSY: o_in_ready = 1'b0;
            PH_DONE: begin
                o_in_ready = i_t_ready;
                o_t_valid  = 1'b1;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    assign o_t = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end else if (r_state == PH_BUSY) begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    // Dividend {0, time, 17 zeros}; low 17 quotient bits are the phase
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_num <= {1'b0, i_time_ms};
            r_rem <= '0;
        end else if (r_state == PH_BUSY) begin
            r_num <= {r_num[30:0], 2'b00};
            r_rem <= step_b[15:0];
            r_q   <= {r_q[14:0], step_a[16], step_b[16]};
        end
    end

endmodule

`default_nettype wire

/* design/lswp_seq.sv */
`default_nettype none

module lswp_seq #(
    parameter int NUM_LEDS = lswp_pkg::NUM_LEDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [3:0]  i_spatial_cycles,
    input  wire logic        i_en,
    input  wire logic        i_t_valid,
    input  wire logic [16:0] i_t,
    output logic             o_t_ready,
    output lswp_pkg::t_seq_item o_item
);
    import lswp_pkg::*;

    localparam int LedW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    logic [16:0]     c_frac [NUM_LEDS];
    logic [LedW-1:0] c_scm  [16];

    logic            r_busy;
    logic [LedW-1:0] r_led;
    logic [LedW-1:0] r_rem;
    logic [16:0]     r_t;
    t_seq_item       r_item;

    logic            last_now;
    logic            emit;
    logic            take;
    logic [LedW:0]   rem_sum;
    logic [LedW-1:0] rem_next;

    // Offset fraction floor(r * 2^17 / N) for remainder r = (cycles * i) mod N
    for (genvar r = 0; r < NUM_LEDS; r++) begin : g_frac
        assign c_frac[r] = 17'((r * Q16_TWO) / NUM_LEDS);
    end

    // cycles mod N
    for (genvar s = 0; s < 16; s++) begin : g_scm
        assign c_scm[s] = LedW'(s % NUM_LEDS);
    end

    assign last_now  = (r_led == LedW'(NUM_LEDS - 1));
    assign emit      = r_busy & i_en;
    assign o_t_ready = ~r_busy | (emit & last_now);
    assign take      = i_t_valid & o_t_ready;

    // Remainder walk: add cycles mod N, wrap once
    assign rem_sum  = {1'b0, r_rem} + {1'b0, c_scm[i_spatial_cycles]};
    assign rem_next = (rem_sum >= (LedW + 1)'(NUM_LEDS))
                      ? LedW'(rem_sum - (LedW + 1)'(NUM_LEDS)) : rem_sum[LedW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_busy <= 1'b1;
        end else if (emit & last_now) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_t   <= i_t;
            r_led <= '0;
            r_rem <= '0;
        end else if (emit) begin
            r_led <= r_led + LedW'(1);
            r_rem <= rem_next;
        end
    end

    // Output stage: wrapped phase of this LED
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item.valid <= r_busy;
        end
        if (i_en) begin
            r_item.led  <= 6'(r_led);
            r_item.last <= last_now;
            r_item.x    <= r_t + c_frac[r_rem];
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

/* design/lswp_shape.sv */
`default_nettype none

module lswp_shape (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire lswp_pkg::t_cfg      i_cfg,
    input  wire lswp_pkg::t_seq_item i_item,
    input  wire logic        i_out_ready,
    output logic             o_en,
    output logic             o_out_valid,
    output logic [5:0]       o_led_index,
    output logic [7:0]       o_level,
    output logic             o_last_led
);
    import lswp_pkg::*;

    localparam int DivStages = 9;
    localparam int PowStages = 4;

    logic [2:0]  mode_eff;

    // Fold stage
    logic        r_uv, r_ulast, r_useg;
    logic [5:0]  r_uled;
    logic [16:0] r_u, r_udiff, r_ufac, r_udiv;
    logic [17:0] x_fold;
    logic [16:0] u_c;
    logic        seg_c;

    // Product stage
    logic        r_pv, r_plast, r_pseg;
    logic [5:0]  r_pled;
    logic [16:0] r_pu, r_pdiv;
    logic [32:0] r_pnum;
    logic [33:0] p_prod;

    // Divide / power stages
    logic        r_dv    [DivStages];
    logic        r_dlast [DivStages];
    logic        r_dseg  [DivStages];
    logic [5:0]  r_dled  [DivStages];
    logic [16:0] r_drem  [DivStages];
    logic [17:0] r_dlow  [DivStages];
    logic [17:0] r_dq    [DivStages];
    logic [16:0] r_dy    [DivStages];
    logic [16:0] r_du    [DivStages];
    logic [16:0] r_ddiv  [DivStages];

    // Output stage
    logic        r_fv, r_flast;
    logic [5:0]  r_fled;
    logic [7:0]  r_flevel;
    logic [16:0] f_q, f_ybend, f_y;
    logic [24:0] f_prod;
    logic [8:0]  f_lvl;

    // One restoring step: {quotient bit, new remainder}
    function automatic logic [17:0] div_step(input logic [16:0] rem,
                                             input logic        bit_in,
                                             input logic [16:0] dv);
        logic [17:0] r;
        r = {rem, bit_in};
        if (r >= {1'b0, dv}) begin
            div_step = {1'b1, 17'(r - {1'b0, dv})};
        end else begin
            div_step = {1'b0, r[16:0]};
        end
    endfunction

    // Whole pipeline moves together unless the output item is held
    assign o_en = ~r_fv | i_out_ready;

    // Undefined modes run as the highest power
    assign mode_eff = (i_cfg.wave_mode > WAVE_POW_MAX) ? WAVE_POW_MAX : i_cfg.wave_mode;

    // Triangle fold and bend segment select
    assign x_fold = TWO_Q16 - {1'b0, i_item.x};
    assign u_c    = i_item.x[16] ? x_fold[16:0] : i_item.x;
    assign seg_c  = (u_c >= {1'b0, i_cfg.bend_x});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv <= 1'b0;
        end else if (o_en) begin
            r_uv <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_uled  <= i_item.led;
            r_ulast <= i_item.last;
            r_u     <= u_c;
            r_useg  <= seg_c;
            r_udiff <= seg_c ? (u_c - {1'b0, i_cfg.bend_x}) : u_c;
            r_ufac  <= seg_c ? (ONE_Q16 - {1'b0, i_cfg.bend_y}) : {1'b0, i_cfg.bend_y};
            r_udiv  <= seg_c ? (ONE_Q16 - {1'b0, i_cfg.bend_x}) : {1'b0, i_cfg.bend_x};
        end
    end

    // Bend numerator
    assign p_prod = r_udiff * r_ufac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (o_en) begin
            r_pv <= r_uv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_pled  <= r_uled;
            r_plast <= r_ulast;
            r_pseg  <= r_useg;
            r_pu    <= r_u;
            r_pdiv  <= r_udiv;
            r_pnum  <= p_prod[32:0];
        end
    end

    // Two quotient bits per stage; power chain multiplies in the first stages
    for (genvar k = 0; k < DivStages; k++) begin : g_div
        logic        w_v, w_last, w_seg;
        logic [5:0]  w_led;
        logic [16:0] w_rem, w_y, w_u, w_div;
        logic [17:0] w_low, w_q;
        logic [17:0] s_a, s_b;
        logic [16:0] s_y;

        if (k == 0) begin : g_first
            assign w_v    = r_pv;
            assign w_last = r_plast;
            assign w_seg  = r_pseg;
            assign w_led  = r_pled;
            assign w_rem  = 17'(r_pnum[32:18]);
            assign w_low  = r_pnum[17:0];
            assign w_q    = '0;
            assign w_y    = r_pu;
            assign w_u    = r_pu;
            assign w_div  = r_pdiv;
        end else begin : g_next
            assign w_v    = r_dv[k-1];
            assign w_last = r_dlast[k-1];
            assign w_seg  = r_dseg[k-1];
            assign w_led  = r_dled[k-1];
            assign w_rem  = r_drem[k-1];
            assign w_low  = r_dlow[k-1];
            assign w_q    = r_dq[k-1];
            assign w_y    = r_dy[k-1];
            assign w_u    = r_du[k-1];
            assign w_div  = r_ddiv[k-1];
        end

        assign s_a = div_step(w_rem, w_low[17], w_div);
        assign s_b = div_step(s_a[16:0], w_low[16], w_div);

        if (k < PowStages) begin : g_pow
            logic [33:0] s_prod;
            assign s_prod = w_y * w_u;
            assign s_y    = (3'(k + 1) < mode_eff) ? s_prod[32:16] : w_y;
        end else begin : g_hold
            assign s_y = w_y;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (o_en) begin
                r_dv[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (o_en) begin
                r_dlast[k] <= w_last;
                r_dseg[k]  <= w_seg;
                r_dled[k]  <= w_led;
                r_drem[k]  <= s_b[16:0];
                r_dlow[k]  <= {w_low[15:0], 2'b00};
                r_dq[k]    <= {w_q[15:0], s_a[17], s_b[17]};
                r_dy[k]    <= s_y;
                r_du[k]    <= w_u;
                r_ddiv[k]  <= w_div;
            end
        end
    end

    // Waveform select, gain, +1 and saturation
    assign f_q     = r_dq[DivStages-1][16:0];
    assign f_ybend = r_dseg[DivStages-1] ? ({1'b0, i_cfg.bend_y} + f_q) : f_q;
    assign f_y     = (i_cfg.wave_mode == WAVE_BEND) ? f_ybend : r_dy[DivStages-1];
    assign f_prod  = f_y * i_cfg.peak_gain;
    assign f_lvl   = f_prod[24:16] + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (o_en) begin
            r_fv <= r_dv[DivStages-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_fled   <= r_dled[DivStages-1];
            r_flast  <= r_dlast[DivStages-1];
            r_flevel <= f_lvl[8] ? 8'hFF : f_lvl[7:0];
        end
    end

    assign o_out_valid = r_fv;
    assign o_led_index = r_fled;
    assign o_level     = r_flevel;
    assign o_last_led  = r_flast;

endmodule

`default_nettype wire

/* design/lswp_checker.sv */
`default_nettype none

`include "led_strip_wave_pattern_generator_unit_defines.svh"

module lswp_checker #(
    parameter int NUM_LEDS = lswp_pkg::NUM_LEDS_DEF
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [5:0] o_led_index,
    input wire logic [7:0] o_level,
    input wire logic       o_last_led
);

    // Frame end marker sits on the final LED only
    `LSWP_CHK_NOW(a_last_index, o_out_valid && o_last_led, o_led_index == 6'(NUM_LEDS - 1), "last item not on final LED")

    // Items of a frame come back to back in LED order
    `LSWP_CHK_NEXT(a_led_order, o_out_valid && i_out_ready && !o_last_led, o_out_valid && (o_led_index == $past(o_led_index) + 6'd1), "gap or misorder inside a frame")

    // The +1 offset keeps every level above zero
    `LSWP_CHK_NOW(a_level_floor, o_out_valid, o_level != 8'd0, "level of zero")

    // The phase divider is busy right after taking an item
    `LSWP_CHK_NEXT(a_in_busy, i_in_valid && o_in_ready, !o_in_ready, "input taken while divider busy")

endmodule

bind led_strip_wave_pattern_generator_unit lswp_checker #(
    .NUM_LEDS (NUM_LEDS)
) u_lswp_checker (.*);

`default_nettype wire

/* sim/led_strip_wave_pattern_generator_unit_tb.sv */
`timescale 1ns / 1ps

module led_strip_wave_pattern_generator_unit_tb;
    import lswp_pkg::*;

    localparam int N_LEDS       = NUM_LEDS_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int GAP_PCT      = 34;

    // Register indexes with no register behind them
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] level;
        logic       last_led;
    } t_led_level;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [31:0] i_time_ms   = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = CFG_PERIOD;
    logic [15:0] i_cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [5:0]  o_led_index;
    logic [7:0]  o_level;
    logic        o_last_led;
    logic        o_cfg_ready;

    // Shadow of the block's registers, levels still to come, run status
    t_cfg        shadow_cfg = CFG_RESET;
    t_led_level  pending_levels[$];
    t_led_level  want_level;
    int          errors     = 0;
    bit          no_gaps    = 1'b0;
    bit          hold_req   = 1'b0;
    int          hold_left  = 0;

    led_strip_wave_pattern_generator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_time_ms   (i_time_ms),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_led_index (o_led_index),
        .o_level     (o_level),
        .o_last_led  (o_last_led),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected levels of all LEDs for one frame time, in LED order
    function automatic void compute_frame_levels(input logic [31:0] t_ms);
        longint unsigned per, phase, offs, x, u, y, lvl, bx, by;
        int              shape_mode;
        t_led_level      entry;
        per        = (shadow_cfg.period_ms == 0) ? 64'd1 : 64'(shadow_cfg.period_ms);
        phase      = ((64'(t_ms) % per) * 64'd131072) / per;
        shape_mode = (shadow_cfg.wave_mode > WAVE_POW_MAX) ? int'(WAVE_POW_MAX)
                                                           : int'(shadow_cfg.wave_mode);
        bx         = 64'(shadow_cfg.bend_x);
        by         = 64'(shadow_cfg.bend_y);
        for (int i = 0; i < N_LEDS; i++) begin
            offs = (64'(shadow_cfg.spatial_cycles) * 64'd2 * 64'(i) * 64'd65536)
                   / 64'(N_LEDS);
            x    = (phase + offs) % 64'd131072;
            // fold into a triangle, 65536 meaning exactly one
            u    = (x < 64'd65536) ? x : 64'd131072 - x;
            if (shape_mode == int'(WAVE_BEND)) begin
                // zero bend point never takes the lower segment
                if (u < bx)
                    y = (u * by) / bx;
                else
                    y = by + ((u - bx) * (64'd65536 - by)) / (64'd65536 - bx);
            end else begin
                y = u;
                for (int k = 1; k < shape_mode; k++)
                    y = (y * u) >> 16;
            end
            lvl = ((y * 64'(shadow_cfg.peak_gain)) >> 16) + 64'd1;
            if (lvl > 64'd255)
                lvl = 64'd255;
            entry.led_index = 6'(i);
            entry.level     = lvl[7:0];
            entry.last_led  = (i == N_LEDS - 1);
            pending_levels.push_back(entry);
        end
    endfunction

    // 0, the top of the range, or any 16-bit value (narrow registers mask it)
    function automatic logic [15:0] edge_or_random(input logic [15:0] top);
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return top;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_time();
        case ($urandom_range(3))
            0:       return 32'($urandom_range(65535));
            1:       return 32'hFFFF_FFFF - 32'($urandom_range(65535));
            default: return $urandom;
        endcase
    endfunction

    // Offer one frame request; returns at the edge that accepts it
    task automatic send_frame(input logic [31:0] t_ms);
        @(negedge i_clk);
        if (!no_gaps) begin
            while ($urandom_range(99) < GAP_PCT) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid = 1'b1;
        i_time_ms  = t_ms;
        do @(posedge i_clk); while (!o_in_ready);
        compute_frame_levels(t_ms);
    endtask

    // Stop offering and wait for every outstanding level
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_levels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PERIOD:  shadow_cfg.period_ms      = val;
            CFG_GAIN:    shadow_cfg.peak_gain      = val[7:0];
            CFG_MODE:    shadow_cfg.wave_mode      = val[2:0];
            CFG_BEND_X:  shadow_cfg.bend_x         = val;
            CFG_BEND_Y:  shadow_cfg.bend_y         = val;
            CFG_SPATIAL: shadow_cfg.spatial_cycles = val[3:0];
            default:     ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = no_gaps || ($urandom_range(99) >= GAP_PCT);
        end
    end

    // Compare each accepted LED item with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_levels.size() == 0) begin
                $error("unexpected item: led_index %0d level %0d last_led %0b",
                       o_led_index, o_level, o_last_led);
                errors++;
            end else begin
                want_level = pending_levels.pop_front();
                if (o_led_index !== want_level.led_index) begin
                    $error("led_index: expected %0d, got %0d",
                           want_level.led_index, o_led_index);
                    errors++;
                end
                if (o_level !== want_level.level) begin
                    $error("level: expected %0d, got %0d (led %0d)",
                           want_level.level, o_level, want_level.led_index);
                    errors++;
                end
                if (o_last_led !== want_level.last_led) begin
                    $error("last_led: expected %0b, got %0b (led %0d)",
                           want_level.last_led, o_last_led, want_level.led_index);
                    errors++;
                end
            end
        end
    end

    // Registers at reset values, time at its extremes
    task automatic test_reset_values();
        send_frame(32'd0);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd4999);
        send_frame(32'd2500);
        wait_idle();
    endtask

    // Every mode, undefined ones included
    task automatic test_wave_shapes();
        for (int m = 0; m < 8; m++) begin
            write_reg(CFG_MODE, 16'(m));
            send_frame(random_time());
            wait_idle();
        end
    endtask

    task automatic test_register_extremes();
        // zero period, no spatial spread
        write_reg(CFG_PERIOD, 16'd0);
        write_reg(CFG_SPATIAL, 16'd0);
        send_frame($urandom);
        wait_idle();
        // half period puts LED 0 at full scale; gain 255 saturates
        write_reg(CFG_PERIOD, 16'd2);
        write_reg(CFG_GAIN, 16'd255);
        write_reg(CFG_MODE, 16'd1);
        write_reg(CFG_SPATIAL, 16'd15);
        send_frame(32'd1);
        wait_idle();
        write_reg(CFG_PERIOD, 16'hFFFF);
        write_reg(CFG_GAIN, 16'd0);
        send_frame(32'hFFFF_FFFF);
        wait_idle();
        // bend point at zero, then at the top
        write_reg(CFG_GAIN, 16'd254);
        write_reg(CFG_MODE, 16'(WAVE_BEND));
        write_reg(CFG_BEND_X, 16'd0);
        write_reg(CFG_BEND_Y, 16'($urandom));
        send_frame($urandom);
        wait_idle();
        write_reg(CFG_BEND_X, 16'hFFFF);
        write_reg(CFG_BEND_Y, 16'd0);
        send_frame($urandom);
        wait_idle();
        write_reg(CFG_BEND_X, 16'd1);
        write_reg(CFG_BEND_Y, 16'hFFFF);
        send_frame($urandom);
        wait_idle();
        // writes to unused indexes change nothing
        write_reg(CFG_SPARE_6, 16'($urandom));
        write_reg(CFG_SPARE_7, 16'($urandom));
        send_frame($urandom);
        wait_idle();
    endtask

    // Random settings per phase, random frame times
    task automatic test_random_frames();
        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            write_reg(CFG_PERIOD,  edge_or_random(16'hFFFF));
            write_reg(CFG_GAIN,    edge_or_random(16'd254));
            write_reg(CFG_MODE,    edge_or_random(16'(WAVE_POW_MAX)));
            write_reg(CFG_BEND_X,  edge_or_random(16'hFFFF));
            write_reg(CFG_BEND_Y,  edge_or_random(16'hFFFF));
            write_reg(CFG_SPATIAL, edge_or_random(16'd15));
            if ($urandom_range(2) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7, 16'($urandom));
            no_gaps = (ph == 4);
            for (int n = 0; n < 22; n++)
                send_frame(random_time());
        end
        no_gaps = 1'b0;
        wait_idle();
    endtask

    // Receiver holds off while frames keep coming, so the block backs up
    task automatic test_output_stall();
        write_reg(CFG_MODE, 16'd2);
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        for (int n = 0; n < 12; n++)
            send_frame(random_time());
        no_gaps = 1'b0;
        wait_idle();
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n    = 1'b1;
        shadow_cfg = CFG_RESET;

        test_reset_values();
        test_wave_shapes();
        test_register_extremes();
        test_random_frames();
        test_output_stall();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_levels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
